### src/tqd_pkg.sv
// ----------------------------------------------------------------------------
// tqd_pkg
// Shared types and constants of the dithered texel quantiser.
// ----------------------------------------------------------------------------
package tqd_pkg;

    localparam int STAGES  = 5;
    localparam int CH_W    = 24;
    localparam int CLAMP_W = 17;
    localparam int PROD_W  = 25;
    localparam int NUM_W   = 27;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 30;
    localparam int SIZE_W  = 11;
    localparam int SLICE_W = 10;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [CLAMP_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [8:0]         SCALE     = 9'd510;
    localparam logic [NUM_W-1:0]   HALF_STEP = 27'd65536;

    localparam logic [31:0] HASH_X = 32'd73856093;
    localparam logic [31:0] HASH_Y = 32'd19349663;
    localparam logic [31:0] HASH_Z = 32'd83492791;
    localparam logic [3:0][31:0] HASH_CH = {32'd3668339987, 32'd1013904226,
                                            32'd2654435761, 32'd0};
    localparam logic [31:0] MIX_A = 32'h7FEB352D;
    localparam logic [31:0] MIX_B = 32'h846CA68B;

    localparam logic [1:0] REG_DITHER = 2'd0;
    localparam logic [1:0] REG_SIZE   = 2'd1;
    localparam logic [1:0] REG_FIRST  = 2'd2;
    localparam logic [1:0] REG_DEPTH  = 2'd3;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage

### src/tqd_chan.sv
// ----------------------------------------------------------------------------
// tqd_chan
// One colour channel: hash finaliser, triangular dither and byte rounding
// over pipeline stages two to five.
// ----------------------------------------------------------------------------
module tqd_chan
(
    input  logic                              clk,
    input  tqd_pkg::pipe_ctrl_t               ctrl,
    input  logic [31:0]                       seed,
    input  logic [tqd_pkg::CLAMP_W-1:0]       level,
    input  logic                              dither,
    output logic [tqd_pkg::BYTE_W-1:0]        byte_out
);

    logic [31:0]                      h1_reg, h1_next;
    logic [31:0]                      m1_reg, m1_next;
    logic [31:0]                      m2_reg, m2_next;
    logic [31:0]                      h2;
    logic [31:0]                      h5;
    logic [tqd_pkg::CLAMP_W-1:0]      c2_reg;
    logic [tqd_pkg::PROD_W-1:0]       p3_reg, p3_next;
    logic [tqd_pkg::PROD_W-1:0]       p4_reg;
    logic signed [16:0]               diff;
    logic signed [tqd_pkg::NUM_W-1:0] num;
    logic [tqd_pkg::BYTE_W-1:0]       byte_reg, byte_next;

    assign h1_next = seed ^ (seed >> 16);
    assign m1_next = h1_reg * tqd_pkg::MIX_A;
    assign p3_next = tqd_pkg::PROD_W'(c2_reg) * tqd_pkg::PROD_W'(tqd_pkg::SCALE);
    assign h2      = m1_reg ^ (m1_reg >> 15);
    assign m2_next = h2 * tqd_pkg::MIX_B;
    assign h5      = m2_reg ^ (m2_reg >> 16);

    always_comb
    begin
        if (dither)
        begin
            diff = signed'({1'b0, h5[15:0]}) - signed'({1'b0, h5[31:16]});
        end
        else
        begin
            diff = '0;
        end
        num = signed'({2'b00, p4_reg}) + tqd_pkg::NUM_W'(diff)
            + signed'(tqd_pkg::HALF_STEP);
        if (num[tqd_pkg::NUM_W-1])
        begin
            byte_next = '0;
        end
        else if (num[25:17] > 9'd255)
        begin
            byte_next = '1;
        end
        else
        begin
            byte_next = num[24:17];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            h1_reg <= h1_next;
            c2_reg <= level;
        end
        if (ctrl.load[2])
        begin
            m1_reg <= m1_next;
            p3_reg <= p3_next;
        end
        if (ctrl.load[3])
        begin
            m2_reg <= m2_next;
            p4_reg <= p3_reg;
        end
        if (ctrl.load[4])
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

### src/tqd_index.sv
// ----------------------------------------------------------------------------
// tqd_index
// Linear texel index ((z*size + y)*size + x) over pipeline stages two to five.
// ----------------------------------------------------------------------------
module tqd_index
#(
    parameter int COORD_BITS = 10,
    parameter int GZ_W       = 11
)
(
    input  logic                          clk,
    input  tqd_pkg::pipe_ctrl_t           ctrl,
    input  logic [GZ_W-1:0]               gz,
    input  logic [COORD_BITS-1:0]         y,
    input  logic [COORD_BITS-1:0]         x,
    input  logic [tqd_pkg::SIZE_W-1:0]    size,
    output logic [tqd_pkg::IDX_W-1:0]     index
);

    localparam int ZP_W = GZ_W + tqd_pkg::SIZE_W;

    logic [ZP_W-1:0]              zp;
    logic [tqd_pkg::IDX_W-1:0]    p2_reg;
    logic [tqd_pkg::IDX_W-1:0]    q3_reg, q3_next;
    logic [tqd_pkg::IDX_W-1:0]    r4_reg, r4_next;
    logic [tqd_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [COORD_BITS-1:0]        y2_reg;
    logic [COORD_BITS-1:0]        x2_reg, x3_reg, x4_reg;

    assign zp       = ZP_W'(gz) * ZP_W'(size);
    assign q3_next  = p2_reg + tqd_pkg::IDX_W'(y2_reg);
    assign r4_next  = q3_reg * tqd_pkg::IDX_W'(size);
    assign idx_next = r4_reg + tqd_pkg::IDX_W'(x4_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            p2_reg <= tqd_pkg::IDX_W'(zp);
            y2_reg <= y;
            x2_reg <= x;
        end
        if (ctrl.load[2])
        begin
            q3_reg <= q3_next;
            x3_reg <= x2_reg;
        end
        if (ctrl.load[3])
        begin
            r4_reg <= r4_next;
            x4_reg <= x3_reg;
        end
        if (ctrl.load[4])
        begin
            idx_reg <= idx_next;
        end
    end

    assign index = idx_reg;

endmodule

### src/texel_quantizer_tpdf_dither.sv
// ----------------------------------------------------------------------------
// texel_quantizer_tpdf_dither
// Quantises volume texels to dithered BGRA bytes with their linear index.
// ----------------------------------------------------------------------------
// Usage: texel requests enter on the s_* stream (four Q7.16 channels and the
// x, y and slab-local z position); results leave on the m_* stream as one
// BGRA word plus the 30-bit linear index, with m_tlast marking the slab's
// last texel. Dither enable, volume size, first slice and slab depth are set
// over the APB port; the user must write them only while the stream is idle,
// which the block does not enforce. A new request is taken every cycle while
// m_tready is high. The five register stages are each one multiply deep at
// most: channel clamp, hash seed, two hash mixing multiplies and the final
// round. Reset empties the pipeline and loads the register defaults (dither
// on, size 256, first slice 0, depth 1). When the receiver stalls, the last
// stage holds its result and the stages behind it keep filling up bubbles,
// so s_tready drops only once every stage holds a request.
// ----------------------------------------------------------------------------
module texel_quantizer_tpdf_dither
#(
    parameter int COORD_BITS = 10
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // red, green, blue, alpha value, pos_x, pos_y, local_z, zero pad
    input  logic [((4*tqd_pkg::CH_W+3*COORD_BITS+7)/8)*8-1:0] s_tdata,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // blue, green, red, alpha byte, texel_index, zero pad
    output logic [63:0]                    m_tdata,
    output logic                           m_tlast,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tqd_pkg::ADDR_W-1:0]     paddr,
    input  logic [tqd_pkg::DATA_W-1:0]     pwdata,
    output logic [tqd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    localparam int GZ_W  = ((COORD_BITS > tqd_pkg::SLICE_W) ? COORD_BITS
                                                            : tqd_pkg::SLICE_W) + 1;
    localparam int CMP_W = ((COORD_BITS + 1 > tqd_pkg::SIZE_W) ? COORD_BITS + 1
                                                               : tqd_pkg::SIZE_W);
    localparam int CH_W  = tqd_pkg::CH_W;
    localparam int NS    = tqd_pkg::STAGES;

    // configuration
    logic                          dither_reg;
    logic [tqd_pkg::SIZE_W-1:0]    size_reg;
    logic [tqd_pkg::SLICE_W-1:0]   first_reg;
    logic [tqd_pkg::SIZE_W-1:0]    depth_reg;
    logic                          cfg_wr;

    // pipeline control
    logic [NS-1:0]                 valid_reg, valid_next;
    logic [NS-1:0]                 rdy;
    tqd_pkg::pipe_ctrl_t           ctrl;

    // stage one
    logic [COORD_BITS-1:0]         in_x, in_y, in_z;
    logic [GZ_W-1:0]               gz_next;
    logic                          done_next;
    logic [COORD_BITS-1:0]         x1_reg, y1_reg;
    logic [GZ_W-1:0]               gz1_reg;
    logic [3:0][tqd_pkg::CLAMP_W-1:0] c1_reg, c1_next;
    logic [NS-1:1]                 done_reg;
    logic                          m_tlast_reg;

    logic [31:0]                   seed_base;
    logic [3:0][tqd_pkg::BYTE_W-1:0] bytes;
    logic [tqd_pkg::IDX_W-1:0]     index;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dither_reg <= 1'b1;
            size_reg   <= 11'd256;
            first_reg  <= '0;
            depth_reg  <= 11'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                tqd_pkg::REG_DITHER: dither_reg <= pwdata[0];
                tqd_pkg::REG_SIZE:   size_reg   <= pwdata[tqd_pkg::SIZE_W-1:0];
                tqd_pkg::REG_FIRST:  first_reg  <= pwdata[tqd_pkg::SLICE_W-1:0];
                tqd_pkg::REG_DEPTH:  depth_reg  <= pwdata[tqd_pkg::SIZE_W-1:0];
                default:             dither_reg <= dither_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            tqd_pkg::REG_DITHER: prdata = tqd_pkg::DATA_W'(dither_reg);
            tqd_pkg::REG_SIZE:   prdata = tqd_pkg::DATA_W'(size_reg);
            tqd_pkg::REG_FIRST:  prdata = tqd_pkg::DATA_W'(first_reg);
            tqd_pkg::REG_DEPTH:  prdata = tqd_pkg::DATA_W'(depth_reg);
            default:             prdata = '0;
        endcase
    end

    // valid chain; a stage loads when it is empty or its successor moves on
    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] | m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] | rdy[i+1];
        end
        valid_next[0] = rdy[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = rdy;
    assign s_tready  = rdy[0];

    // stage one: clamp, global z, end-of-slab test
    assign in_x    = s_tdata[4*CH_W +: COORD_BITS];
    assign in_y    = s_tdata[4*CH_W + COORD_BITS +: COORD_BITS];
    assign in_z    = s_tdata[4*CH_W + 2*COORD_BITS +: COORD_BITS];
    assign gz_next = GZ_W'(first_reg) + GZ_W'(in_z);

    assign done_next = (CMP_W'(in_x) + CMP_W'(1) == CMP_W'(size_reg))
                     & (CMP_W'(in_y) + CMP_W'(1) == CMP_W'(size_reg))
                     & (CMP_W'(in_z) + CMP_W'(1) == CMP_W'(depth_reg));

    always_comb
    begin
        for (int ch = 0; ch < 4; ch++)
        begin
            if (s_tdata[ch*CH_W + CH_W - 1])
            begin
                c1_next[ch] = '0;
            end
            else if (s_tdata[ch*CH_W +: CH_W] > CH_W'(tqd_pkg::ONE_Q16))
            begin
                c1_next[ch] = tqd_pkg::ONE_Q16;
            end
            else
            begin
                c1_next[ch] = s_tdata[ch*CH_W +: tqd_pkg::CLAMP_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x1_reg      <= in_x;
            y1_reg      <= in_y;
            gz1_reg     <= gz_next;
            c1_reg      <= c1_next;
            done_reg[1] <= done_next;
        end
        for (int i = 2; i < NS; i++)
        begin
            if (rdy[i-1])
            begin
                done_reg[i] <= done_reg[i-1];
            end
        end
        if (rdy[NS-1])
        begin
            m_tlast_reg <= done_reg[NS-1];
        end
    end

    // hash seed shared by the four channels
    assign seed_base = (32'(x1_reg) * tqd_pkg::HASH_X)
                     ^ (32'(y1_reg) * tqd_pkg::HASH_Y)
                     ^ (32'(gz1_reg) * tqd_pkg::HASH_Z);

    for (genvar g = 0; g < 4; g++)
    begin : g_chan
        tqd_chan u_chan
        (
            .clk      (clk),
            .ctrl     (ctrl),
            .seed     (seed_base ^ tqd_pkg::HASH_CH[g]),
            .level    (c1_reg[g]),
            .dither   (dither_reg),
            .byte_out (bytes[g])
        );
    end

    tqd_index
    #(
        .COORD_BITS (COORD_BITS),
        .GZ_W       (GZ_W)
    )
    u_index
    (
        .clk   (clk),
        .ctrl  (ctrl),
        .gz    (gz1_reg),
        .y     (y1_reg),
        .x     (x1_reg),
        .size  (size_reg),
        .index (index)
    );

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {2'b00, index, bytes[3], bytes[0], bytes[1], bytes[2]};
    assign m_tlast  = m_tlast_reg;

endmodule
